@@ rtl/prah_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the pointer rest/activity heatmap.
// Used by the top level and the divider; depends on nothing.
package prah_pkg;

  // Field widths fixed by the item format.
  localparam int COORD_W      = 8;
  localparam int OP_W         = 2;
  localparam int WEIGHT_OUT_W = 24;
  localparam int COUNT_W      = 32;
  localparam int RES_W        = 9;
  localparam int CFG_IDX_W    = 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  // Reset value of both resolution registers.
  localparam logic [RES_W-1:0] RES_RESET = 9'd256;

  // Saturating limit of the 32-bit counters.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Input item.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic                    is_rest;
    logic                    out_of_range;
    logic [WEIGHT_OUT_W-1:0] activity_weight;
    logic [WEIGHT_OUT_W-1:0] rest_weight;
    logic [COUNT_W-1:0]      mean_activity_run;
    logic [COUNT_W-1:0]      mean_rest_run;
  } out_item_t;

  // Request to the shared divider.
  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  // Response of the shared divider.
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] quotient;
  } div_rsp_t;

  // Saturating increment of a 32-bit counter.
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

@@ rtl/pointer_rest_activity_heatmap_core.sv @@
`timescale 1ns / 1ps
// Pointer rest/activity heatmap, top level. Uses prah_pkg, prah_heat_mem and prah_divider.
// Sample, read and unused ops: held in ST_ACCESS until the output can load, then the result
// is registered, set by the heatmap read-modify-write through the registered read port.
// Report op: the result follows two divisions on the shared divider, activity mean then rest
// mean. No new item is accepted until the block is back in ST_IDLE.
// Reset (synchronous, rst_n low) starts a clearing pass over all MAP_COLS*MAP_ROWS cells
// (65536 by default) during which no item is accepted; configuration writes are taken.
module pointer_rest_activity_heatmap_core
  import prah_pkg::*;
#(
  parameter int MAP_COLS    = 256,
  parameter int MAP_ROWS    = 256,
  parameter int WEIGHT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [RES_W-1:0]     cfg_wdata
);

  localparam int CELLS  = MAP_COLS * MAP_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0]      LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_ACCESS   = 6'b000100,
    ST_DIV_ACT  = 6'b001000,
    ST_DIV_REST = 6'b010000,
    ST_REPORT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [RES_W-1:0]   map_width_r, map_width_nxt;
  logic [RES_W-1:0]   map_height_r, map_height_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [COORD_W-1:0] x_r, x_nxt;
  logic [COORD_W-1:0] y_r, y_nxt;
  logic               ok_r, ok_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [COORD_W-1:0] last_x_r, last_x_nxt;
  logic [COORD_W-1:0] last_y_r, last_y_nxt;
  logic               have_last_r, have_last_nxt;
  logic               last_rest_r, last_rest_nxt;
  logic [COUNT_W-1:0] act_smp_r, act_smp_nxt;
  logic [COUNT_W-1:0] rest_smp_r, rest_smp_nxt;
  logic [COUNT_W-1:0] act_runs_r, act_runs_nxt;
  logic [COUNT_W-1:0] rest_runs_r, rest_runs_nxt;
  logic [COUNT_W-1:0] mean_act_r, mean_act_nxt;
  logic [COUNT_W-1:0] mean_rest_r, mean_rest_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               accept;
  logic               in_ok;
  logic [ADDR_W-1:0]  in_addr;
  logic               can_load;
  logic               smp_rest;
  logic               clearing;
  logic               access_done;
  logic               act_wr_en, rest_wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [WEIGHT_BITS-1:0] act_rd, rest_rd;
  logic [WEIGHT_BITS-1:0] act_wr, rest_wr;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;
  assign clearing = (state_r == ST_CLEAR);

  // Range test and cell address of the incoming coordinates.
  assign in_ok = ({1'b0, in_data.pos_x} < map_width_r)
              && ({1'b0, in_data.pos_y} < map_height_r)
              && (32'(in_data.pos_x) < 32'(MAP_COLS))
              && (32'(in_data.pos_y) < 32'(MAP_ROWS));
  assign in_addr = ADDR_W'(32'(in_data.pos_y) * 32'(MAP_COLS) + 32'(in_data.pos_x));

  // Classification of the held sample against the previous position.
  assign smp_rest = have_last_r && (x_r == last_x_r) && (y_r == last_y_r);

  assign access_done = (state_r == ST_ACCESS) && can_load;

  // Heatmap write port: zero fill during the clearing pass, else a saturating increment.
  assign act_wr_en  = clearing
                   || (access_done && (op_r == OP_SAMPLE) && ok_r && !smp_rest);
  assign rest_wr_en = clearing
                   || (access_done && (op_r == OP_SAMPLE) && ok_r && smp_rest);
  assign wr_addr = clearing ? clr_addr_r : addr_r;
  assign act_wr  = clearing ? '0 : ((act_rd == WEIGHT_MAX) ? act_rd : act_rd + 1'b1);
  assign rest_wr = clearing ? '0 : ((rest_rd == WEIGHT_MAX) ? rest_rd : rest_rd + 1'b1);

  prah_heat_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (WEIGHT_BITS)
  ) u_act_mem (
    .clk     (clk),
    .rd_en   (accept && in_ok),
    .rd_addr (in_addr),
    .rd_data (act_rd),
    .wr_en   (act_wr_en),
    .wr_addr (wr_addr),
    .wr_data (act_wr)
  );

  prah_heat_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (WEIGHT_BITS)
  ) u_rest_mem (
    .clk     (clk),
    .rd_en   (accept && in_ok),
    .rd_addr (in_addr),
    .rd_data (rest_rd),
    .wr_en   (rest_wr_en),
    .wr_addr (wr_addr),
    .wr_data (rest_wr)
  );

  // Divider requests: activity mean first, then rest mean when the first finishes.
  always_comb begin
    div_req.start    = (accept && (in_data.op == OP_REPORT))
                    || ((state_r == ST_DIV_ACT) && div_rsp.done);
    div_req.dividend = (state_r == ST_IDLE) ? act_smp_r : rest_smp_r;
    div_req.divisor  = (state_r == ST_IDLE) ? act_runs_r : rest_runs_r;
  end

  prah_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer and state update.
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    op_nxt         = op_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    ok_nxt         = ok_r;
    addr_nxt       = addr_r;
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    have_last_nxt  = have_last_r;
    last_rest_nxt  = last_rest_r;
    act_smp_nxt    = act_smp_r;
    rest_smp_nxt   = rest_smp_r;
    act_runs_nxt   = act_runs_r;
    rest_runs_nxt  = rest_runs_r;
    mean_act_nxt   = mean_act_r;
    mean_rest_nxt  = mean_rest_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    // Configuration writes.
    if (cfg_we) begin
      case (cfg_idx)
        REG_MAP_WIDTH:  map_width_nxt  = cfg_wdata;
        REG_MAP_HEIGHT: map_height_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_data.op;
          x_nxt    = in_data.pos_x;
          y_nxt    = in_data.pos_y;
          ok_nxt   = in_ok;
          addr_nxt = in_addr;
          state_nxt = (in_data.op == OP_REPORT) ? ST_DIV_ACT : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          case (op_r)
            OP_SAMPLE: begin
              out_data_nxt.is_rest      = smp_rest;
              out_data_nxt.out_of_range = !ok_r;
              if (smp_rest) begin
                rest_smp_nxt = sat_inc(rest_smp_r);
              end else begin
                act_smp_nxt = sat_inc(act_smp_r);
              end
              if (smp_rest != last_rest_r) begin
                if (smp_rest) begin
                  rest_runs_nxt = sat_inc(rest_runs_r);
                end else begin
                  act_runs_nxt = sat_inc(act_runs_r);
                end
              end
              last_x_nxt    = x_r;
              last_y_nxt    = y_r;
              have_last_nxt = 1'b1;
              last_rest_nxt = smp_rest;
            end
            OP_READ: begin
              out_data_nxt.out_of_range = !ok_r;
              if (ok_r) begin
                out_data_nxt.activity_weight = WEIGHT_OUT_W'(act_rd);
                out_data_nxt.rest_weight     = WEIGHT_OUT_W'(rest_rd);
              end
            end
            default: ;
          endcase
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV_ACT: begin
        if (div_rsp.done) begin
          mean_act_nxt = (act_runs_r == '0) ? '0 : div_rsp.quotient;
          state_nxt    = ST_DIV_REST;
        end
      end
      ST_DIV_REST: begin
        if (div_rsp.done) begin
          mean_rest_nxt = (rest_runs_r == '0) ? '0 : div_rsp.quotient;
          state_nxt     = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (can_load) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt                   = '0;
          out_data_nxt.mean_activity_run = mean_act_r;
          out_data_nxt.mean_rest_run     = mean_rest_r;
          state_nxt                      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state, initialised by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      map_width_r  <= RES_RESET;
      map_height_r <= RES_RESET;
      last_x_r     <= '0;
      last_y_r     <= '0;
      have_last_r  <= 1'b0;
      last_rest_r  <= 1'b1;
      act_smp_r    <= '0;
      rest_smp_r   <= '0;
      act_runs_r   <= '0;
      rest_runs_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      have_last_r  <= have_last_nxt;
      last_rest_r  <= last_rest_nxt;
      act_smp_r    <= act_smp_nxt;
      rest_smp_r   <= rest_smp_nxt;
      act_runs_r   <= act_runs_nxt;
      rest_runs_r  <= rest_runs_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Held item and result payload.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    ok_r        <= ok_nxt;
    addr_r      <= addr_nxt;
    mean_act_r  <= mean_act_nxt;
    mean_rest_r <= mean_rest_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/prah_heat_mem.sv @@
`timescale 1ns / 1ps
// One heatmap store: a single-port-write, single-port-read memory with registered read data.
// Depends on nothing but its parameters.
module prah_heat_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/prah_divider.sv @@
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on prah_pkg for the request and response structs.
module prah_divider
  import prah_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(COUNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COUNT_W - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] quot_r, quot_nxt;
  logic [COUNT_W-1:0] dvsr_r, dvsr_nxt;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   diff;
  logic               fits;

  // Shift in the next dividend bit and trial-subtract the divisor.
  assign rem_sh = {rem_r, quot_r[COUNT_W-1]};
  assign diff   = rem_sh - {1'b0, dvsr_r};
  assign fits   = (rem_sh >= {1'b0, dvsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quot_nxt = req.dividend;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      quot_nxt = {quot_r[COUNT_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quot_r;

endmodule
